// ===== sv/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue.
// Holds command and status codes, the decoded operation type, the task
// record that travels from the front part to the back part, and defaults.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Default number of entries in the ring store.
  localparam int CAPACITY_DEFAULT = 16;

  // Fixed field widths.
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  // Depth of the task queue between the front and back parts.
  localparam int TASK_Q_DEPTH = 2;
  localparam int TASK_Q_PTR_W = $clog2(TASK_Q_DEPTH);
  localparam int TASK_Q_CNT_W = $clog2(TASK_Q_DEPTH + 1);

  // Command codes as they arrive on the input channel.
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

  // Status codes returned with every result.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

  // Decoded operation.
  typedef enum logic [2:0] {
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_SEARCH,
    OP_NOP
  } op_t;

  // One classified command waiting for the back part.
  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] value;
  } task_t;

  // Back part sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POP,
    BK_SEARCH
  } back_state_t;

  // Map a raw command code to an operation; unused codes do nothing.
  function automatic op_t classify(input logic [CMD_W-1:0] cmd);
    op_t op;
    unique case (cmd)
      CMD_PUSH_BACK:  op = OP_PUSH_BACK;
      CMD_PUSH_FRONT: op = OP_PUSH_FRONT;
      CMD_POP_FRONT:  op = OP_POP_FRONT;
      CMD_POP_BACK:   op = OP_POP_BACK;
      CMD_SEARCH:     op = OP_SEARCH;
      default:        op = OP_NOP;
    endcase
    return op;
  endfunction

endpackage

// ===== sv/deq_if.sv =====
// ----------------------------------------------------------------------------
// deq_if: channel interfaces for the double-ended queue.
// deq_cmd_if carries command beats in, deq_res_if carries result beats out.
// ----------------------------------------------------------------------------

// Command channel: one beat per command.
interface deq_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [deq_pkg::CMD_W-1:0]          cmd;
  logic signed [deq_pkg::DATA_W-1:0]  data_in;

  modport source (output valid, output cmd, output data_in, input ready);
  modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

// Result channel: one beat per command; count width follows the capacity.
interface deq_res_if #(
  parameter int CountW = $clog2(deq_pkg::CAPACITY_DEFAULT + 1)
);
  logic                               valid;
  logic                               ready;
  logic [deq_pkg::STATUS_W-1:0]       status;
  logic signed [deq_pkg::DATA_W-1:0]  data_out;
  logic [CountW-1:0]                  count;

  modport source (output valid, output status, output data_out, output count,
                  input ready);
  modport sink   (input valid, input status, input data_out, input count,
                  output ready);
endinterface

// ===== sv/deq_front.sv =====
// ----------------------------------------------------------------------------
// deq_front: command intake for the double-ended queue.
// Accepts command beats, decodes them into tasks and holds them in a short
// queue so the intake keeps taking beats while the back part is busy.
// ----------------------------------------------------------------------------
module deq_front (
  input  logic           clk,
  input  logic           rst,
  deq_cmd_if.sink        cmd_ch,
  output logic           task_valid,
  output deq_pkg::task_t task_out,
  input  logic           task_ready
);

  deq_pkg::task_t                      q [deq_pkg::TASK_Q_DEPTH];
  logic [deq_pkg::TASK_Q_PTR_W-1:0]    wr_ptr;
  logic [deq_pkg::TASK_Q_PTR_W-1:0]    rd_ptr;
  logic [deq_pkg::TASK_Q_CNT_W-1:0]    fill;
  logic                                push;
  logic                                pop;
  deq_pkg::task_t                      decoded;

  // Decode the incoming beat into a task.
  always_comb begin
    decoded.op    = deq_pkg::classify(cmd_ch.cmd);
    decoded.value = cmd_ch.data_in;
  end

  // Handshake on both sides of the queue.
  assign cmd_ch.ready = (fill != deq_pkg::TASK_Q_CNT_W'(deq_pkg::TASK_Q_DEPTH));
  assign push         = cmd_ch.valid && cmd_ch.ready;
  assign task_valid   = (fill != '0);
  assign pop          = task_valid && task_ready;
  assign task_out     = q[rd_ptr];

  // Queue storage; entries need no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= decoded;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == deq_pkg::TASK_Q_PTR_W'(deq_pkg::TASK_Q_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == deq_pkg::TASK_Q_PTR_W'(deq_pkg::TASK_Q_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== sv/deq_back.sv =====
// ----------------------------------------------------------------------------
// deq_back: execution part of the double-ended queue.
// Owns the ring store, head pointer and element count, carries out one task
// at a time and places its result in an output register.
// ----------------------------------------------------------------------------
module deq_back #(
  parameter int CAPACITY = deq_pkg::CAPACITY_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           task_valid,
  input  deq_pkg::task_t task_in,
  output logic           task_ready,
  deq_res_if.source      res_ch
);

  localparam int IdxW   = $clog2(CAPACITY);
  localparam int CountW = $clog2(CAPACITY + 1);
  localparam int SumW   = CountW + 1;
  localparam logic [IdxW-1:0]   LastIdx = IdxW'(CAPACITY - 1);
  localparam logic [CountW-1:0] CapCount = CountW'(CAPACITY);

  // Fold a sum below twice the capacity back into the ring.
  function automatic logic [IdxW-1:0] wrap_idx(input logic [SumW-1:0] s);
    logic [SumW-1:0] t;
    t = (s >= SumW'(CAPACITY)) ? s - SumW'(CAPACITY) : s;
    return t[IdxW-1:0];
  endfunction

  // Step one entry forward around the ring.
  function automatic logic [IdxW-1:0] inc_idx(input logic [IdxW-1:0] p);
    return (p == LastIdx) ? '0 : p + 1'b1;
  endfunction

  // Ring store and its registered read port.
  logic [deq_pkg::DATA_W-1:0] mem [CAPACITY];
  logic [deq_pkg::DATA_W-1:0] rd_data;

  deq_pkg::back_state_t       state, state_next;
  logic [IdxW-1:0]            head, head_next;
  logic [CountW-1:0]          count, count_next;
  logic [IdxW-1:0]            ptr, ptr_next;
  logic [CountW-1:0]          scan, scan_next;
  logic [deq_pkg::DATA_W-1:0] key;

  logic                       res_valid;
  logic [deq_pkg::STATUS_W-1:0] res_status;
  logic [deq_pkg::DATA_W-1:0] res_data;
  logic [CountW-1:0]          res_count;

  logic                       wr_en;
  logic [IdxW-1:0]            wr_addr;
  logic                       rd_en;
  logic [IdxW-1:0]            rd_addr;
  logic                       out_load;
  logic [deq_pkg::STATUS_W-1:0] out_status;
  logic [deq_pkg::DATA_W-1:0] out_data;

  logic                       out_free;
  logic                       take;
  logic                       is_empty;
  logic                       is_full;
  logic                       hit;
  logic                       scan_done;

  assign out_free  = !res_valid || res_ch.ready;
  assign take      = (state == deq_pkg::BK_IDLE) && task_valid && out_free;
  assign is_empty  = (count == '0);
  assign is_full   = (count == CapCount);
  assign hit       = (rd_data == key);
  assign scan_done = (scan == count);

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      deq_pkg::BK_IDLE: begin
        if (take && !is_empty) begin
          if (task_in.op == deq_pkg::OP_POP_FRONT || task_in.op == deq_pkg::OP_POP_BACK) begin
            state_next = deq_pkg::BK_POP;
          end else if (task_in.op == deq_pkg::OP_SEARCH) begin
            state_next = deq_pkg::BK_SEARCH;
          end
        end
      end
      deq_pkg::BK_POP: begin
        state_next = deq_pkg::BK_IDLE;
      end
      deq_pkg::BK_SEARCH: begin
        if (hit || scan_done) begin
          state_next = deq_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = deq_pkg::BK_IDLE;
      end
    endcase
  end

  // Datapath control for each state.
  always_comb begin
    task_ready = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = head;
    rd_en      = 1'b0;
    rd_addr    = ptr;
    head_next  = head;
    count_next = count;
    ptr_next   = ptr;
    scan_next  = scan;
    out_load   = 1'b0;
    out_status = deq_pkg::STATUS_OK;
    out_data   = '0;
    unique case (state)
      deq_pkg::BK_IDLE: begin
        if (take) begin
          task_ready = 1'b1;
          unique case (task_in.op)
            deq_pkg::OP_PUSH_BACK: begin
              out_load = 1'b1;
              if (is_full) begin
                out_status = deq_pkg::STATUS_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = wrap_idx(SumW'(head) + SumW'(count));
                count_next = count + 1'b1;
              end
            end
            deq_pkg::OP_PUSH_FRONT: begin
              out_load = 1'b1;
              if (is_full) begin
                out_status = deq_pkg::STATUS_FULL;
              end else begin
                head_next  = (head == '0) ? LastIdx : head - 1'b1;
                wr_en      = 1'b1;
                wr_addr    = head_next;
                count_next = count + 1'b1;
              end
            end
            deq_pkg::OP_POP_FRONT: begin
              if (is_empty) begin
                out_load   = 1'b1;
                out_status = deq_pkg::STATUS_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = head;
                head_next  = inc_idx(head);
                count_next = count - 1'b1;
              end
            end
            deq_pkg::OP_POP_BACK: begin
              if (is_empty) begin
                out_load   = 1'b1;
                out_status = deq_pkg::STATUS_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = wrap_idx(SumW'(head) + SumW'(count) - 1'b1);
                count_next = count - 1'b1;
              end
            end
            deq_pkg::OP_SEARCH: begin
              if (is_empty) begin
                out_load   = 1'b1;
                out_status = deq_pkg::STATUS_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = head;
                ptr_next  = inc_idx(head);
                scan_next = CountW'(1);
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      deq_pkg::BK_POP: begin
        out_load = 1'b1;
        out_data = rd_data;
      end
      deq_pkg::BK_SEARCH: begin
        if (hit) begin
          out_load = 1'b1;
        end else if (scan_done) begin
          out_load   = 1'b1;
          out_status = deq_pkg::STATUS_NOT_FOUND;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = ptr;
          ptr_next  = inc_idx(ptr);
          scan_next = scan + 1'b1;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Ring store write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= task_in.value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Search key and scan position; payload only.
  always_ff @(posedge clk) begin
    if (task_ready) begin
      key <= task_in.value;
    end
    ptr  <= ptr_next;
    scan <= scan_next;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= deq_pkg::BK_IDLE;
      head      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (res_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      res_status <= out_status;
      res_data   <= out_data;
      res_count  <= count_next;
    end
  end

  assign res_ch.valid    = res_valid;
  assign res_ch.status   = res_status;
  assign res_ch.data_out = res_data;
  assign res_ch.count    = res_count;

endmodule

// ===== sv/double_ended_queue_with_search.sv =====
// A command beat passes the task queue to the back part, which loads the
// result register; a pop from a non-empty queue also passes the registered
// store read and BK_POP, a search the read and BK_SEARCH. One push per cycle
// while the result channel takes every beat; a pop or search keeps the back
// part busy, and the search walks the ring store's single read port one entry
// a cycle. Reset (rst, synchronous) empties both queues, not the ring store.
// ----------------------------------------------------------------------------
// double_ended_queue_with_search: bounded deque of 32-bit values with search.
// A front part takes and decodes command beats into a short task queue; a
// back part runs each task against the ring store and returns a result beat.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search #(
  parameter int CAPACITY = deq_pkg::CAPACITY_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  deq_cmd_if.sink   cmd_ch,
  deq_res_if.source res_ch
);

  logic           task_valid;
  logic           task_ready;
  deq_pkg::task_t task_data;

  // Command intake and task queue.
  deq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_ch     (cmd_ch),
    .task_valid (task_valid),
    .task_out   (task_data),
    .task_ready (task_ready)
  );

  // Task execution against the ring store.
  deq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .task_valid (task_valid),
    .task_in    (task_data),
    .task_ready (task_ready),
    .res_ch     (res_ch)
  );

endmodule
